// ===== design/mfog_pkg.sv =====
// Package for the matrix fill-order generator: sizes, payload and
// configuration types, register indexes. No dependencies.
package mfog_pkg;

    // Sizes
    localparam int MAX_DIM    = 16;
    localparam int DATA_WIDTH = 32;
    localparam int POS_W      = $clog2(MAX_DIM);
    localparam int CNT_W      = $clog2(MAX_DIM * MAX_DIM);
    localparam int CFG_W      = 5;
    localparam int CFG_IDX_W  = 2;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_FILL_MODE    = CFG_IDX_W'(2);

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic [POS_W-1:0]             pos_t;
    typedef logic [CNT_W-1:0]             count_t;

    typedef enum logic [2:0] {
        MODE_COL_MAJOR = 3'd0,
        MODE_ROW_MAJOR = 3'd1,
        MODE_SNAKE     = 3'd2,
        MODE_SPIRAL    = 3'd3,
        MODE_REVERSE   = 3'd4
    } fill_mode_t;

    typedef enum logic [1:0] {
        DIR_RIGHT = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_UP    = 2'd3
    } dir_t;

    // Effective configuration, already clamped
    typedef struct packed {
        pos_t       rows_m1;
        pos_t       cols_m1;
        fill_mode_t mode;
        count_t     total_m1;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        rows_m1:  pos_t'(3),
        cols_m1:  pos_t'(3),
        mode:     MODE_COL_MAJOR,
        total_m1: count_t'(15)
    };

    // One result item
    typedef struct packed {
        pos_t  dest_row;
        pos_t  dest_col;
        data_t out_value;
        logic  matrix_done;
    } out_item_t;

endpackage

// ===== design/mfog_if.sv =====
// Stream interfaces of the matrix fill-order generator: element input and
// placed-element output. Depends on mfog_pkg.
interface mfog_in_if;
    import mfog_pkg::*;

    logic  valid;
    logic  ready;
    data_t element_value;

    modport source (output valid, output element_value, input ready);
    modport sink   (input valid, input element_value, output ready);
endinterface

interface mfog_out_if;
    import mfog_pkg::*;

    logic  valid;
    logic  ready;
    pos_t  dest_row;
    pos_t  dest_col;
    data_t out_value;
    logic  matrix_done;

    modport source (output valid, output dest_row, output dest_col, output out_value,
                    output matrix_done, input ready);
    modport sink   (input valid, input dest_row, input dest_col, input out_value,
                    input matrix_done, output ready);
endinterface

// ===== design/mfog_config.sv =====
// Configuration registers: clamps row/column counts and mode on write and
// keeps the element total. Depends on mfog_pkg.
module mfog_config (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_en,
    input  logic [mfog_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mfog_pkg::CFG_W-1:0]     cfg_data,
    output mfog_pkg::cfg_t                 cfg,
    output mfog_pkg::cfg_t                 cfg_next,
    output logic                           restart
);
    import mfog_pkg::*;

    cfg_t                  cfg_reg;
    logic [2*(POS_W+1)-1:0] total_prod;

    // 0 taken as 1, above MAX_DIM taken as MAX_DIM; returns count minus one
    function automatic pos_t eff_dim_m1(logic [CFG_W-1:0] raw);
        pos_t res;
        if (raw == '0)
            res = '0;
        else if (int'(raw) > MAX_DIM)
            res = pos_t'(MAX_DIM - 1);
        else
            res = pos_t'(raw - CFG_W'(1));
        return res;
    endfunction

    // Only bits 2:0 are decoded; unknown codes there behave as row-major
    function automatic fill_mode_t eff_mode(logic [CFG_W-1:0] raw);
        fill_mode_t res;
        unique case (raw[2:0])
            3'd0:    res = MODE_COL_MAJOR;
            3'd2:    res = MODE_SNAKE;
            3'd3:    res = MODE_SPIRAL;
            3'd4:    res = MODE_REVERSE;
            default: res = MODE_ROW_MAJOR;
        endcase
        return res;
    endfunction

    // Register write decode; any known index restarts the walker
    always_comb
    begin
        cfg_next = cfg_reg;
        restart  = 1'b0;
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_ROW_COUNT:
                begin
                    cfg_next.rows_m1 = eff_dim_m1(cfg_data);
                    restart          = 1'b1;
                end
                REG_COLUMN_COUNT:
                begin
                    cfg_next.cols_m1 = eff_dim_m1(cfg_data);
                    restart          = 1'b1;
                end
                REG_FILL_MODE:
                begin
                    cfg_next.mode = eff_mode(cfg_data);
                    restart       = 1'b1;
                end
                default: ;
            endcase
        end
        total_prod = {1'b0, cfg_next.rows_m1} * {1'b0, cfg_next.cols_m1}
                   + {(POS_W+2)'(0), cfg_next.rows_m1}
                   + {(POS_W+2)'(0), cfg_next.cols_m1};
        cfg_next.total_m1 = count_t'(total_prod);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

    // Stored total always matches the stored dimensions
    a_total_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (2*(POS_W+1))'(cfg_reg.total_m1) + (2*(POS_W+1))'(1) ==
        ({1'b0, cfg_reg.rows_m1} + (POS_W+1)'(1)) * ({1'b0, cfg_reg.cols_m1} + (POS_W+1)'(1)))
        else $error("total does not match rows times columns");

endmodule

// ===== design/mfog_walker.sv =====
// Position walker: gives each accepted element its row/column and steps
// the walker for the selected fill pattern. Depends on mfog_pkg, mfog_if.
module mfog_walker (
    input  logic                  clk,
    input  logic                  rst_n,
    mfog_in_if.sink               element_in,
    input  mfog_pkg::cfg_t        cfg,
    input  mfog_pkg::cfg_t        cfg_next,
    input  logic                  restart,
    input  logic                  stage_ready,
    output logic                  push,
    output mfog_pkg::out_item_t   result
);
    import mfog_pkg::*;

    typedef struct packed {
        pos_t   row;
        pos_t   col;
        dir_t   dir;
        pos_t   top;
        pos_t   bottom;
        pos_t   left;
        pos_t   right;
        count_t count;
    } walk_t;

    walk_t walk_reg;
    walk_t walk_next;
    walk_t step;
    logic  last;

    // Start of a matrix for a given configuration
    function automatic walk_t start_of(cfg_t c);
        walk_t w;
        w.dir    = DIR_RIGHT;
        w.top    = '0;
        w.left   = '0;
        w.bottom = c.rows_m1;
        w.right  = c.cols_m1;
        w.count  = '0;
        if (c.mode == MODE_REVERSE)
        begin
            w.row = c.rows_m1;
            w.col = c.cols_m1;
        end
        else
        begin
            w.row = '0;
            w.col = '0;
        end
        return w;
    endfunction

    assign element_in.ready = stage_ready;
    assign push             = element_in.valid && stage_ready;
    assign last             = (walk_reg.count >= cfg.total_m1);

    // Result straight from the current walker position
    always_comb
    begin
        result.dest_row    = walk_reg.row;
        result.dest_col    = walk_reg.col;
        result.out_value   = element_in.element_value;
        result.matrix_done = last;
    end

    // One step of the walker
    always_comb
    begin
        step       = walk_reg;
        step.count = walk_reg.count + count_t'(1);
        unique case (cfg.mode)
            MODE_COL_MAJOR:
            begin
                if (walk_reg.row >= cfg.rows_m1)
                begin
                    step.row = '0;
                    step.col = walk_reg.col + pos_t'(1);
                end
                else
                    step.row = walk_reg.row + pos_t'(1);
            end
            MODE_SNAKE:
            begin
                if (walk_reg.dir == DIR_RIGHT)
                begin
                    if (walk_reg.col >= cfg.cols_m1)
                    begin
                        step.dir = DIR_LEFT;
                        step.row = walk_reg.row + pos_t'(1);
                    end
                    else
                        step.col = walk_reg.col + pos_t'(1);
                end
                else
                begin
                    if (walk_reg.col == '0)
                    begin
                        step.dir = DIR_RIGHT;
                        step.row = walk_reg.row + pos_t'(1);
                    end
                    else
                        step.col = walk_reg.col - pos_t'(1);
                end
            end
            MODE_SPIRAL:
            begin
                unique case (walk_reg.dir)
                    DIR_RIGHT:
                    begin
                        if (walk_reg.col >= walk_reg.right)
                        begin
                            step.dir = DIR_DOWN;
                            step.top = walk_reg.top + pos_t'(1);
                            step.row = walk_reg.row + pos_t'(1);
                        end
                        else
                            step.col = walk_reg.col + pos_t'(1);
                    end
                    DIR_DOWN:
                    begin
                        if (walk_reg.row >= walk_reg.bottom)
                        begin
                            step.dir   = DIR_LEFT;
                            step.right = walk_reg.right - pos_t'(1);
                            step.col   = walk_reg.col - pos_t'(1);
                        end
                        else
                            step.row = walk_reg.row + pos_t'(1);
                    end
                    DIR_LEFT:
                    begin
                        if (walk_reg.col <= walk_reg.left)
                        begin
                            step.dir    = DIR_UP;
                            step.bottom = walk_reg.bottom - pos_t'(1);
                            step.row    = walk_reg.row - pos_t'(1);
                        end
                        else
                            step.col = walk_reg.col - pos_t'(1);
                    end
                    DIR_UP:
                    begin
                        if (walk_reg.row <= walk_reg.top)
                        begin
                            step.dir  = DIR_RIGHT;
                            step.left = walk_reg.left + pos_t'(1);
                            step.col  = walk_reg.col + pos_t'(1);
                        end
                        else
                            step.row = walk_reg.row - pos_t'(1);
                    end
                endcase
            end
            MODE_REVERSE:
            begin
                if (walk_reg.col == '0)
                begin
                    step.col = cfg.cols_m1;
                    step.row = walk_reg.row - pos_t'(1);
                end
                else
                    step.col = walk_reg.col - pos_t'(1);
            end
            default:
            begin
                if (walk_reg.col >= cfg.cols_m1)
                begin
                    step.col = '0;
                    step.row = walk_reg.row + pos_t'(1);
                end
                else
                    step.col = walk_reg.col + pos_t'(1);
            end
        endcase
    end

    // Register write restarts; last element wraps to the start
    always_comb
    begin
        walk_next = walk_reg;
        if (restart)
            walk_next = start_of(cfg_next);
        else if (push)
            walk_next = last ? start_of(cfg) : step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            walk_reg <= start_of(CFG_RESET);
        else
            walk_reg <= walk_next;
    end

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        walk_reg.count <= cfg.total_m1)
        else $error("element count past end of matrix");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        walk_reg.row <= cfg.rows_m1 && walk_reg.col <= cfg.cols_m1)
        else $error("walker outside matrix");

    a_wrap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        push && last |=> walk_reg.count == '0)
        else $error("walker did not restart after last element");

endmodule

// ===== design/mfog_out_skid.sv =====
// Result register with skid stage, so ready to the input side is a
// register. Depends on mfog_pkg, mfog_if.
module mfog_out_skid (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mfog_pkg::out_item_t item,
    output logic                stage_ready,
    mfog_out_if.source          result_out
);
    import mfog_pkg::*;

    logic      main_valid_reg;
    logic      main_valid_next;
    out_item_t main_item_reg;
    out_item_t main_item_next;
    logic      skid_valid_reg;
    logic      skid_valid_next;
    out_item_t skid_item_reg;
    out_item_t skid_item_next;
    logic      pop;

    assign pop         = main_valid_reg && result_out.ready;
    assign stage_ready = !skid_valid_reg;

    // Main/skid refill
    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_item_next  = main_item_reg;
        skid_valid_next = skid_valid_reg;
        skid_item_next  = skid_item_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_item_next  = skid_item_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = push;
                main_item_next  = item;
            end
        end
        else if (push)
        begin
            if (main_valid_reg)
            begin
                skid_valid_next = 1'b1;
                skid_item_next  = item;
            end
            else
            begin
                main_valid_next = 1'b1;
                main_item_next  = item;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_item_reg <= main_item_next;
        skid_item_reg <= skid_item_next;
    end

    assign result_out.valid       = main_valid_reg;
    assign result_out.dest_row    = main_item_reg.dest_row;
    assign result_out.dest_col    = main_item_reg.dest_col;
    assign result_out.out_value   = main_item_reg.out_value;
    assign result_out.matrix_done = main_item_reg.matrix_done;

    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held with empty result register");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !push)
        else $error("transfer taken with skid stage full");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && result_out.ready |=> !skid_valid_reg)
        else $error("skid entry not moved on after result transfer");

endmodule

// ===== design/matrix_fill_order_generator.sv =====
// Top level of the matrix fill-order generator: configuration registers,
// position walker and result skid stage. Depends on mfog_pkg, mfog_if.
//
//   channel      dir  handshake     payload
//   element_in   in   valid/ready   element_value (32b signed)
//   result_out   out  valid/ready   dest_row, dest_col, out_value, matrix_done
//   cfg_*        in   write enable  cfg_index (2b), cfg_data (5b)
//
// One element per clock while ready is high; the edge that takes the element
// loads its result into the result register, or the skid entry if it stalls.
// Ready drops only when both the result register and the skid entry are full.
// Reset gives a 4x4 column-major walk from row 0, column 0; no clearing pass.
// Any register write restarts the walker at the start of a new matrix.
module matrix_fill_order_generator (
    input  logic                           clk,
    input  logic                           rst_n,
    mfog_in_if.sink                        element_in,
    mfog_out_if.source                     result_out,
    input  logic                           cfg_write_en,
    input  logic [mfog_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mfog_pkg::CFG_W-1:0]     cfg_data
);
    import mfog_pkg::*;

    cfg_t      cfg;
    cfg_t      cfg_next;
    logic      restart;
    logic      stage_ready;
    logic      push;
    out_item_t result;

    mfog_config u_config (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg),
        .cfg_next     (cfg_next),
        .restart      (restart)
    );

    mfog_walker u_walker (
        .clk         (clk),
        .rst_n       (rst_n),
        .element_in  (element_in),
        .cfg         (cfg),
        .cfg_next    (cfg_next),
        .restart     (restart),
        .stage_ready (stage_ready),
        .push        (push),
        .result      (result)
    );

    mfog_out_skid u_out_skid (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .item        (result),
        .stage_ready (stage_ready),
        .result_out  (result_out)
    );

endmodule
